/* hw/rtl/dbs_pkg.sv */
// dbs_pkg: shared types and constants of the dbscan clustering core
// item and result structs, command and register codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package dbs_pkg;

	localparam int COORD_W   = 16;
	localparam int IDX_W     = 12;
	localparam int FLD_W     = 13;
	localparam int EPS_W     = 35;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 35;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_SQ  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS  = 2'd2;

	localparam logic [EPS_W-1:0] EPS_RESET  = 35'd8028;
	localparam logic [FLD_W-1:0] MINP_RESET = 13'd2;
	localparam int               PC_RESET   = 4096;

	typedef struct packed {
		logic [1:0]                command;
		logic [IDX_W-1:0]          point_index;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
	} cmd_item_t;

	typedef struct packed {
		logic [FLD_W-1:0] label;
		logic [FLD_W-1:0] cluster_count;
	} res_item_t;

	typedef enum logic [1:0] {
		SCAN_P_COUNT,
		SCAN_P_COLLECT,
		SCAN_S_COUNT,
		SCAN_S_JOIN
	} scan_mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_RCLR,
		ST_OUTER,
		ST_OCHK,
		ST_PLAT,
		ST_SRD,
		ST_SGO,
		ST_SWT,
		ST_SEND,
		ST_SEED,
		ST_SDRD,
		ST_SDCHK
	} state_t;

endpackage

/* hw/rtl/dbs_dist.sv */
// dbs_dist: pipelined squared distance check, shared by every scan
// three stages: difference magnitudes, squares, sum and compare
// depends on dbs_pkg
`timescale 1ns / 1ps

module dbs_dist import dbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by,
	input  logic [EPS_W-1:0]          eps,
	output logic                      done,
	output logic                      near
);

	localparam int DW   = COORD_W + 1;
	localparam int SQW  = 2 * DW;
	localparam int SUMW = SQW + 1;
	localparam int CMPW = (SUMW > EPS_W) ? SUMW : EPS_W;

	logic [DW-1:0]  dx, dy;
	logic [DW-1:0]  mx_s1, my_s1;
	logic [SQW-1:0] sx_s2, sy_s2;
	logic           near_s3;
	logic           v_s1, v_s2, v_s3;

	assign dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
	assign dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1   <= dx[DW-1] ? (~dx + DW'(1)) : dx;
		my_s1   <= dy[DW-1] ? (~dy + DW'(1)) : dy;
		sx_s2   <= SQW'(mx_s1) * SQW'(mx_s1);
		sy_s2   <= SQW'(my_s1) * SQW'(my_s1);
		near_s3 <= CMPW'(SUMW'(sx_s2) + SUMW'(sy_s2)) <= CMPW'(eps);
	end

	assign done = v_s3;
	assign near = near_s3;

endmodule

/* hw/rtl/dbs_pmem.sv */
// dbs_pmem: point coordinate store, one write and one registered read port
// depends on dbs_pkg
`timescale 1ns / 1ps

module dbs_pmem import dbs_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(MAX_POINTS)-1:0]     waddr,
	input  logic signed [COORD_W-1:0]         wx,
	input  logic signed [COORD_W-1:0]         wy,
	input  logic                              re,
	input  logic [$clog2(MAX_POINTS)-1:0]     raddr,
	output logic signed [COORD_W-1:0]         rx,
	output logic signed [COORD_W-1:0]         ry
);

	logic [COORD_W-1:0] x_mem [MAX_POINTS];
	logic [COORD_W-1:0] y_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
		if (re) begin
			rx <= x_mem[raddr];
			ry <= y_mem[raddr];
		end
	end

endmodule

/* hw/rtl/dbs_ctrl.sv */
// dbs_ctrl: sequencer for load, read and run, with label store and seed list
// drives the point store and the shared distance check
// depends on dbs_pkg, dbs_pmem, dbs_dist
`timescale 1ns / 1ps

module dbs_ctrl import dbs_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  cmd_item_t                         request,
	output logic                              busy,
	output logic                              done,
	output res_item_t                         result,
	input  logic [$clog2(MAX_POINTS+1)-1:0]   point_count,
	input  logic [EPS_W-1:0]                  eps,
	input  logic [FLD_W-1:0]                  min_points
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = $clog2(MAX_POINTS + 2);
	localparam int MW = (CW > FLD_W) ? CW : FLD_W;

	localparam logic [LW:0] LBL_UNCL  = '0;
	localparam logic [LW:0] LBL_NOISE = {1'b1, {LW{1'b0}}};

	state_t     state_q, state_d;
	scan_mode_t mode_q;
	logic [CW-1:0] i_q, j_q, k_q, st_q, nb_q;
	logic [LW-1:0] nc_q;
	logic signed [COORD_W-1:0] px_q, py_q, rx_q, ry_q;
	logic          done_q, rd_ok_q;
	res_item_t     result_q;

	logic [LW:0]   label_mem [MAX_POINTS];
	logic [IW-1:0] seed_mem [MAX_POINTS];
	logic [LW:0]   label_rd_q;
	logic [IW-1:0] seed_rd_q;

	logic          lbl_we, lbl_re, seed_we, seed_re, pm_we, pm_re, dist_start;
	logic [IW-1:0] lbl_waddr, lbl_raddr, pm_raddr;
	logic [LW:0]   lbl_wdata;
	logic signed [COORD_W-1:0] pm_x, pm_y;
	logic          dist_done, dist_near;

	logic accept, idx_ok, i_end, j_end, sparse, lbl_uncl, lbl_noise, seed_room, same_loc;

	assign accept    = start && (state_q == ST_IDLE);
	assign idx_ok    = 32'(request.point_index) < MAX_POINTS;
	assign i_end     = (i_q == point_count);
	assign j_end     = (j_q == point_count);
	assign sparse    = MW'(nb_q) < MW'(min_points);
	assign lbl_uncl  = (label_rd_q == LBL_UNCL);
	assign lbl_noise = (label_rd_q == LBL_NOISE);
	assign seed_room = st_q < CW'(MAX_POINTS);
	assign same_loc  = (pm_x == px_q) && (pm_y == py_q);

	dbs_pmem #(.MAX_POINTS(MAX_POINTS)) u_pmem (
		.clk   (clk),
		.we    (pm_we),
		.waddr (IW'(request.point_index)),
		.wx    (request.x_coord),
		.wy    (request.y_coord),
		.re    (pm_re),
		.raddr (pm_raddr),
		.rx    (pm_x),
		.ry    (pm_y)
	);

	dbs_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.ax     (rx_q),
		.ay     (ry_q),
		.bx     (pm_x),
		.by     (pm_y),
		.eps    (eps),
		.done   (dist_done),
		.near   (dist_near)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (j_q == CW'(MAX_POINTS)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (request.command)
						CMD_RUN:  state_d = ST_RCLR;
						CMD_READ: state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_RCLR: begin
				if (j_end) state_d = ST_OUTER;
			end
			ST_OUTER: state_d = i_end ? ST_IDLE : ST_OCHK;
			ST_OCHK:  state_d = lbl_uncl ? ST_PLAT : ST_OUTER;
			ST_PLAT:  state_d = ST_SRD;
			ST_SRD:   state_d = j_end ? ST_SEND : ST_SGO;
			ST_SGO:   state_d = ST_SWT;
			ST_SWT: begin
				if (dist_done) state_d = ST_SRD;
			end
			ST_SEND: begin
				case (mode_q)
					SCAN_P_COUNT:   state_d = sparse ? ST_OUTER : ST_SRD;
					SCAN_P_COLLECT: state_d = ST_SEED;
					SCAN_S_COUNT:   state_d = sparse ? ST_SEED : ST_SRD;
					default:        state_d = ST_SEED;
				endcase
			end
			ST_SEED:  state_d = (k_q >= st_q) ? ST_OUTER : ST_SDRD;
			ST_SDRD:  state_d = ST_SDCHK;
			ST_SDCHK: state_d = same_loc ? ST_SEED : ST_SRD;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		busy       = (state_q != ST_IDLE);
		lbl_we     = 1'b0;
		lbl_waddr  = j_q[IW-1:0];
		lbl_wdata  = LBL_UNCL;
		lbl_re     = 1'b0;
		lbl_raddr  = j_q[IW-1:0];
		seed_we    = 1'b0;
		seed_re    = 1'b0;
		pm_we      = 1'b0;
		pm_re      = 1'b0;
		pm_raddr   = j_q[IW-1:0];
		dist_start = 1'b0;
		case (state_q)
			ST_INIT: begin
				lbl_we = (j_q != CW'(MAX_POINTS));
			end
			ST_IDLE: begin
				lbl_raddr = IW'(request.point_index);
				lbl_re    = accept;
				if (accept && (request.command == CMD_LOAD) && idx_ok) begin
					pm_we     = 1'b1;
					lbl_we    = 1'b1;
					lbl_waddr = IW'(request.point_index);
				end
			end
			ST_RCLR: begin
				lbl_we = !j_end;
			end
			ST_OUTER: begin
				lbl_re    = !i_end;
				lbl_raddr = i_q[IW-1:0];
			end
			ST_OCHK: begin
				pm_re    = 1'b1;
				pm_raddr = i_q[IW-1:0];
			end
			ST_SRD: begin
				pm_re = !j_end;
			end
			ST_SGO: begin
				dist_start = 1'b1;
				lbl_re     = 1'b1;
			end
			ST_SWT: begin
				lbl_wdata = {1'b0, nc_q};
				if (dist_done && dist_near) begin
					case (mode_q)
						SCAN_P_COLLECT: begin
							lbl_we  = 1'b1;
							seed_we = seed_room;
						end
						SCAN_S_JOIN: begin
							lbl_we  = lbl_uncl || lbl_noise;
							seed_we = lbl_uncl && seed_room;
						end
						default: begin
							lbl_we = 1'b0;
						end
					endcase
				end
			end
			ST_SEND: begin
				lbl_waddr = i_q[IW-1:0];
				lbl_wdata = LBL_NOISE;
				lbl_we    = (mode_q == SCAN_P_COUNT) && sparse;
			end
			ST_SEED: begin
				seed_re = (k_q < st_q);
			end
			ST_SDRD: begin
				pm_re    = 1'b1;
				pm_raddr = seed_rd_q;
			end
			default: begin
				busy = (state_q != ST_IDLE);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lbl_we) label_mem[lbl_waddr] <= lbl_wdata;
		if (lbl_re) label_rd_q <= label_mem[lbl_raddr];
		if (seed_we) seed_mem[st_q[IW-1:0]] <= j_q[IW-1:0];
		if (seed_re) seed_rd_q <= seed_mem[k_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			mode_q   <= SCAN_P_COUNT;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			st_q     <= '0;
			nb_q     <= '0;
			nc_q     <= LW'(1);
			done_q   <= 1'b0;
			rd_ok_q  <= 1'b0;
			result_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_INIT: begin
					if (j_q != CW'(MAX_POINTS)) j_q <= j_q + CW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						case (request.command)
							CMD_RUN: begin
								j_q <= '0;
							end
							CMD_READ: begin
								rd_ok_q <= idx_ok;
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q                 <= 1'b1;
					result_q.cluster_count <= '0;
					result_q.label         <= (rd_ok_q && !label_rd_q[LW]) ?
						FLD_W'(label_rd_q[LW-1:0]) : '0;
				end
				ST_RCLR: begin
					if (!j_end) begin
						j_q <= j_q + CW'(1);
					end else begin
						i_q  <= '0;
						nc_q <= LW'(1);
					end
				end
				ST_OUTER: begin
					if (i_end) begin
						done_q                 <= 1'b1;
						result_q.label         <= '0;
						result_q.cluster_count <= FLD_W'(nc_q - LW'(1));
					end
				end
				ST_OCHK: begin
					if (!lbl_uncl) i_q <= i_q + CW'(1);
				end
				ST_PLAT: begin
					px_q   <= pm_x;
					py_q   <= pm_y;
					rx_q   <= pm_x;
					ry_q   <= pm_y;
					nb_q   <= '0;
					j_q    <= '0;
					mode_q <= SCAN_P_COUNT;
				end
				ST_SWT: begin
					if (dist_done) begin
						j_q <= j_q + CW'(1);
						if (dist_near) begin
							case (mode_q)
								SCAN_P_COLLECT: begin
									if (seed_room) st_q <= st_q + CW'(1);
								end
								SCAN_S_JOIN: begin
									if (lbl_uncl && seed_room) st_q <= st_q + CW'(1);
								end
								default: begin
									nb_q <= nb_q + CW'(1);
								end
							endcase
						end
					end
				end
				ST_SEND: begin
					case (mode_q)
						SCAN_P_COUNT: begin
							if (sparse) begin
								i_q <= i_q + CW'(1);
							end else begin
								mode_q <= SCAN_P_COLLECT;
								j_q    <= '0;
								st_q   <= '0;
							end
						end
						SCAN_P_COLLECT: begin
							k_q <= '0;
						end
						SCAN_S_COUNT: begin
							if (sparse) begin
								k_q <= k_q + CW'(1);
							end else begin
								mode_q <= SCAN_S_JOIN;
								j_q    <= '0;
							end
						end
						default: begin
							k_q <= k_q + CW'(1);
						end
					endcase
				end
				ST_SEED: begin
					if (k_q >= st_q) begin
						nc_q <= nc_q + LW'(1);
						i_q  <= i_q + CW'(1);
					end
				end
				ST_SDCHK: begin
					if (same_loc) begin
						k_q <= k_q + CW'(1);
					end else begin
						rx_q   <= pm_x;
						ry_q   <= pm_y;
						nb_q   <= '0;
						j_q    <= '0;
						mode_q <= SCAN_S_COUNT;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* hw/rtl/dbscan_clustering_core.sv */
// dbscan_clustering_core: top level, configuration registers and sequencer
// depends on dbs_pkg, dbs_ctrl
//
// channel   signals                               handshake
// command   start, busy, request                  taken when start && !busy
// result    done, result                          one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index,      taken when valid && ready
//           cfg_data
//
// after reset a clearing pass runs over the label store with busy high. a load
// is answered from the idle state, a read through a read state. a run first
// clears the labels of point_count points, then runs distance checks through
// the shared distance pipeline; each unclassified candidate is scanned once,
// twice if it is dense, and each seed at a new location up to twice. results
// are registered when the work ends and cannot be held off.
`timescale 1ns / 1ps

module dbscan_clustering_core import dbs_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_item_t            request,
	output logic                 done,
	output res_item_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int CW     = $clog2(MAX_POINTS + 1);
	localparam int PC_RST = (MAX_POINTS < PC_RESET) ? MAX_POINTS : PC_RESET;

	logic [CW-1:0]    point_count_q;
	logic [EPS_W-1:0] eps_q;
	logic [FLD_W-1:0] min_points_q;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CW'(PC_RST);
			eps_q         <= EPS_RESET;
			min_points_q  <= MINP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_COUNT: begin
					if (32'(cfg_data[FLD_W-1:0]) > MAX_POINTS)
						point_count_q <= CW'(MAX_POINTS);
					else
						point_count_q <= CW'(cfg_data[FLD_W-1:0]);
				end
				CFG_EPSILON_SQ: begin
					eps_q <= cfg_data[EPS_W-1:0];
				end
				CFG_MIN_POINTS: begin
					min_points_q <= cfg_data[FLD_W-1:0];
				end
				default: begin
					eps_q <= eps_q;
				end
			endcase
		end
	end

	dbs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.request     (request),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.point_count (point_count_q),
		.eps         (eps_q),
		.min_points  (min_points_q)
	);

endmodule
